### rtl/pird_pkg.sv
`timescale 1ns / 1ps
// Shared constants, types and helper functions for the packed image RLE decoder.
// No dependencies; every other file of the block imports this package.
package pird_pkg;

    // Palette geometry. The color index of a token is taken modulo the entry count.
    localparam int PALETTE_ENTRIES = 256;
    localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

    // Longest span list one token may produce.
    localparam int MAX_SPANS = 34;
    localparam int CNT_W     = $clog2(MAX_SPANS + 1);

    // Token decoding.
    localparam logic [11:0] LITERAL_LIMIT = 12'd2047;

    // Field widths.
    localparam int CMD_W   = 2;
    localparam int CFG_W   = 12;
    localparam int CFG_AW  = 2;
    localparam int TOKEN_W = 24;
    localparam int POS_W   = 13;
    localparam int COLOR_W = 16;

    // Item commands.
    localparam logic [CMD_W-1:0] CMD_PALETTE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TOKEN   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_START   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_AW-1:0] CFG_ORIGIN_X = 2'd0;
    localparam logic [CFG_AW-1:0] CFG_ORIGIN_Y = 2'd1;
    localparam logic [CFG_AW-1:0] CFG_WIDTH_M1 = 2'd2;
    localparam logic [CFG_AW-1:0] CFG_ROWS     = 2'd3;

    // Configuration reset values.
    localparam logic [CFG_W-1:0] RST_WIDTH_M1 = 12'd319;
    localparam logic [CFG_W-1:0] RST_ROWS     = 12'd199;

    // One input item as seen by the datapath.
    typedef struct packed {
        logic [CMD_W-1:0]   command;
        logic [7:0]         palette_index;
        logic [7:0]         red;
        logic [7:0]         green;
        logic [7:0]         blue;
        logic [TOKEN_W-1:0] token;
    } t_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;   // input transaction completes this cycle
        logic calc;   // register the length of the next span
        logic load;   // place the span in the output register and move the cursor
    } t_ctl_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic begin_spans;  // the offered item is a token that will produce spans
        logic out_room;     // the output register can take a span this cycle
        logic span_last;    // the span being loaded ends the token
    } t_dp_status;

    // Pack RGB888 into RGB565.
    function automatic logic [COLOR_W-1:0] rgb565(input logic [7:0] r,
                                                  input logic [7:0] g,
                                                  input logic [7:0] b);
        rgb565 = {r[7:3], g[7:2], b[7:3]};
    endfunction

endpackage

### rtl/pird_ifs.sv
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the decoder: input items and output spans.
// Depends on pird_pkg for the field widths.
interface pird_item_if;
    import pird_pkg::*;

    logic               valid;
    logic               ready;
    logic [CMD_W-1:0]   command;
    logic [7:0]         palette_index;
    logic [7:0]         red;
    logic [7:0]         green;
    logic [7:0]         blue;
    logic [TOKEN_W-1:0] token;

    modport source (output valid, command, palette_index, red, green, blue, token,
                    input ready);
    modport sink   (input valid, command, palette_index, red, green, blue, token,
                    output ready);
endinterface

interface pird_span_if;
    import pird_pkg::*;

    logic               valid;
    logic               ready;
    logic [POS_W-1:0]   span_x;
    logic [POS_W-1:0]   span_y;
    logic [POS_W-1:0]   span_length;
    logic [COLOR_W-1:0] pixel_color;
    logic               last_span;
    logic               picture_done;

    modport source (output valid, span_x, span_y, span_length, pixel_color, last_span,
                    picture_done, input ready);
    modport sink   (input valid, span_x, span_y, span_length, pixel_color, last_span,
                    picture_done, output ready);
endinterface

### rtl/pird_ctrl.sv
`timescale 1ns / 1ps
// Sequencing state machine of the decoder: accepts items and steps through spans.
// Depends on pird_pkg for the command and status structs.
module pird_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  pird_pkg::t_dp_status  i_status,
    output pird_pkg::t_ctl_cmd    o_cmd
);
    import pird_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CALC = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    assign o_in_ready = (r_state == ST_IDLE);
    assign o_cmd.take = i_in_valid && o_in_ready;
    assign o_cmd.calc = (r_state == ST_CALC);
    assign o_cmd.load = (r_state == ST_EMIT) && i_status.out_room;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (o_cmd.take && i_status.begin_spans) begin
                    n_state = ST_CALC;
                end
            end
            ST_CALC: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_status.out_room) begin
                    n_state = i_status.span_last ? ST_IDLE : ST_CALC;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    // A span is only emitted after its length was worked out.
    a_emit_after_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT) |-> ($past(r_state) == ST_CALC || $past(r_state) == ST_EMIT))
        else $error("emit state entered without a length calculation");

    // A token that produces spans moves straight on to the length calculation.
    a_take_to_calc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.take && i_status.begin_spans) |=> (r_state == ST_CALC))
        else $error("span sequence did not start after a token transaction");

    // A stalled span keeps the sequencer in its emit state.
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_EMIT && !i_status.out_room) |=> (r_state == ST_EMIT))
        else $error("emit state left while the output was stalled");
`endif

endmodule

### rtl/pird_datapath.sv
`timescale 1ns / 1ps
// Datapath of the decoder: configuration, palette memory, cursor, span arithmetic
// and the output register. Depends on pird_pkg and pird_span_if.
module pird_datapath (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pird_pkg::CFG_AW-1:0]   i_cfg_index,
    input  logic [pird_pkg::CFG_W-1:0]    i_cfg_data,
    input  pird_pkg::t_item               i_item,
    input  pird_pkg::t_ctl_cmd            i_cmd,
    output pird_pkg::t_dp_status          o_status,
    pird_span_if.source                   o_span
);
    import pird_pkg::*;

    // Configuration registers.
    logic [CFG_W-1:0] r_org_x;
    logic [CFG_W-1:0] r_org_y;
    logic [CFG_W-1:0] r_wm1;
    logic [CFG_W-1:0] r_rows;

    // Cursor and per-token state.
    logic [POS_W-1:0]   r_cur_x;
    logic [POS_W-1:0]   r_cur_y;
    logic               r_finished;
    logic               r_literal;
    logic               r_phase2;
    logic [11:0]        r_remain;
    logic [PAL_AW-1:0]  r_second_idx;
    logic [CNT_W-1:0]   r_count;
    logic [POS_W-1:0]   r_len;

    // Palette memory with registered read.
    logic [COLOR_W-1:0] r_palette [PALETTE_ENTRIES];
    logic [COLOR_W-1:0] r_rd_data;

    // Output register.
    logic               r_out_valid;
    logic [POS_W-1:0]   r_out_x;
    logic [POS_W-1:0]   r_out_y;
    logic [POS_W-1:0]   r_out_len;
    logic [COLOR_W-1:0] r_out_color;
    logic               r_out_last;
    logic               r_out_done;

    logic [11:0]        w_hi;
    logic [11:0]        w_lo;
    logic               w_is_token;
    logic               w_cur_done;
    logic               w_hi_literal;
    logic [POS_W-1:0]   w_wm1;
    logic [POS_W-1:0]   w_room;
    logic [POS_W-1:0]   w_len;
    logic [POS_W-1:0]   w_nx_sum;
    logic               w_wrap;
    logic [POS_W-1:0]   w_new_x;
    logic [POS_W-1:0]   w_new_y;
    logic               w_fin_new;
    logic [11:0]        w_remain_new;
    logic [CNT_W-1:0]   w_count_new;
    logic               w_last;
    logic               w_pal_we;
    logic               w_pal_re;
    logic [PAL_AW-1:0]  w_pal_ra;

    assign w_hi         = i_item.token[23:12];
    assign w_lo         = i_item.token[11:0];
    assign w_is_token   = (i_item.command == CMD_TOKEN);
    assign w_cur_done   = r_finished || (r_cur_y >= {1'b0, r_rows});
    assign w_hi_literal = (w_hi > LITERAL_LIMIT);
    assign w_wm1        = {1'b0, r_wm1};

    // Length of the next span: the rest of the run, capped at the room left on the line.
    always_comb begin
        if (r_cur_x <= w_wm1) begin
            w_room = w_wm1 + POS_W'(1) - r_cur_x;
        end else begin
            w_room = POS_W'(1);
        end
        w_len = ({1'b0, r_remain} < w_room) ? {1'b0, r_remain} : w_room;
    end

    // Cursor movement after the span held in r_len.
    assign w_nx_sum     = r_cur_x + r_len;
    assign w_wrap       = (w_nx_sum > w_wm1);
    assign w_new_x      = w_wrap ? '0 : w_nx_sum;
    assign w_new_y      = w_wrap ? (r_cur_y + POS_W'(1)) : r_cur_y;
    assign w_fin_new    = (w_new_y >= {1'b0, r_rows});
    assign w_remain_new = r_remain - r_len[11:0];
    assign w_count_new  = r_count + CNT_W'(1);

    always_comb begin
        if (r_literal) begin
            w_last = r_phase2 || w_fin_new;
        end else begin
            w_last = (w_remain_new == '0) || w_fin_new || (w_count_new == CNT_W'(MAX_SPANS));
        end
    end

    assign o_status.begin_spans = w_is_token && !w_cur_done && (w_hi_literal || (w_lo != '0));
    assign o_status.out_room    = !r_out_valid || o_span.ready;
    assign o_status.span_last   = w_last;

    // Both color indexes of a literal reduce to the low index bits, since the
    // literal bias is a multiple of the palette size.
    assign w_pal_we = i_cmd.take && (i_item.command == CMD_PALETTE)
                      && ({1'b0, i_item.palette_index} < 9'(PALETTE_ENTRIES));
    assign w_pal_re = (i_cmd.take && w_is_token) || (i_cmd.load && r_literal && !w_last);
    assign w_pal_ra = i_cmd.take ? w_hi[PAL_AW-1:0] : r_second_idx;

    always_ff @(posedge i_clk) begin
        if (w_pal_we) begin
            r_palette[i_item.palette_index[PAL_AW-1:0]] <=
                rgb565(i_item.red, i_item.green, i_item.blue);
        end
        if (w_pal_re) begin
            r_rd_data <= r_palette[w_pal_ra];
        end
    end

    // Configuration writes.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_org_x <= '0;
            r_org_y <= '0;
            r_wm1   <= RST_WIDTH_M1;
            r_rows  <= RST_ROWS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_ORIGIN_X: r_org_x <= i_cfg_data;
                CFG_ORIGIN_Y: r_org_y <= i_cfg_data;
                CFG_WIDTH_M1: r_wm1   <= i_cfg_data;
                CFG_ROWS:     r_rows  <= i_cfg_data;
                default:      r_org_x <= r_org_x;
            endcase
        end
    end

    // Cursor and token state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cur_x    <= '0;
            r_cur_y    <= '0;
            r_finished <= 1'b1;
            r_literal  <= 1'b0;
            r_phase2   <= 1'b0;
            r_remain   <= '0;
            r_count    <= '0;
        end else if (i_cmd.take) begin
            if (i_item.command == CMD_START) begin
                r_cur_x    <= '0;
                r_cur_y    <= '0;
                r_finished <= (r_rows == '0);
            end else if (w_is_token) begin
                if (w_cur_done) begin
                    r_finished <= 1'b1;
                end else begin
                    r_literal <= w_hi_literal;
                    r_phase2  <= 1'b0;
                    r_remain  <= w_hi_literal ? 12'd1 : w_lo;
                    r_count   <= '0;
                end
            end
        end else if (i_cmd.load) begin
            r_cur_x <= w_new_x;
            r_cur_y <= w_new_y;
            r_count <= w_count_new;
            if (w_fin_new) begin
                r_finished <= 1'b1;
            end
            if (r_literal && !w_last) begin
                r_phase2 <= 1'b1;
                r_remain <= 12'd1;
            end else begin
                r_remain <= w_remain_new;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_second_idx <= w_lo[PAL_AW-1:0];
        end
        if (i_cmd.calc) begin
            r_len <= w_len;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.load) begin
            r_out_valid <= 1'b1;
        end else if (o_span.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_out_x     <= {1'b0, r_org_x} + r_cur_x;
            r_out_y     <= {1'b0, r_org_y} + r_cur_y;
            r_out_len   <= r_len;
            r_out_color <= r_rd_data;
            r_out_last  <= w_last;
            r_out_done  <= w_fin_new;
        end
    end

    assign o_span.valid        = r_out_valid;
    assign o_span.span_x       = r_out_x;
    assign o_span.span_y       = r_out_y;
    assign o_span.span_length  = r_out_len;
    assign o_span.pixel_color  = r_out_color;
    assign o_span.last_span    = r_out_last;
    assign o_span.picture_done = r_out_done;

`ifndef SYNTHESIS
    // Spans are only produced while the picture is still open.
    a_load_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> !r_finished)
        else $error("span emitted after the picture finished");

    // A span that reaches the last row closes the picture.
    a_finish_sticks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.load && w_fin_new) |=> r_finished)
        else $error("picture not marked finished after its last row");

    // The span counter never passes the per-token limit.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(MAX_SPANS))
        else $error("span counter beyond its limit");

    // A new span never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load |-> (!r_out_valid || o_span.ready))
        else $error("output register overwritten while stalled");
`endif

endmodule

### rtl/packed_image_rle_decoder.sv
`timescale 1ns / 1ps
// Top level of the packed image run-length decoder: joins controller and datapath.
// Depends on pird_pkg, pird_ifs (channel interfaces), pird_ctrl and pird_datapath.
//
//   Channel   Direction  Handshake      Carries
//   i_item    in         valid/ready    command, palette entry (RGB888) or 24-bit token
//   o_span    out        valid/ready    one horizontal span: position, length, RGB565 color
//   i_cfg_*   in         write enable   origin, line width minus one, picture rows
//
// A palette write, a start or an unknown command is taken in one transaction. A token is
// taken in its transaction and then needs two steps per span it produces (length calculation,
// then span load); a literal token produces up to two spans and a run over n rows n spans.
// The span sequencer in the controller and the single palette read port set this sequence.
// Reset is synchronous and active low; it clears the cursor, marks the picture finished
// and restores the configuration defaults, while the palette stays undefined until written.
// A stall on o_span holds the sequencer in its load step; the next item is accepted as
// soon as the last span of a token sits in the output register.
module packed_image_rle_decoder (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pird_pkg::CFG_AW-1:0]   i_cfg_index,
    input  logic [pird_pkg::CFG_W-1:0]    i_cfg_data,
    pird_item_if.sink                     i_item,
    pird_span_if.source                   o_span
);
    import pird_pkg::*;

    t_item      w_item;
    t_ctl_cmd   w_cmd;
    t_dp_status w_status;
    logic       w_in_ready;

    // The datapath sees the input payload as one packed item.
    assign w_item.command       = i_item.command;
    assign w_item.palette_index = i_item.palette_index;
    assign w_item.red           = i_item.red;
    assign w_item.green         = i_item.green;
    assign w_item.blue          = i_item.blue;
    assign w_item.token         = i_item.token;

    // The controller owns the input handshake; items are taken only between tokens.
    assign i_item.ready = w_in_ready;

    pird_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_item.valid),
        .o_in_ready (w_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    // The datapath holds the palette, the cursor and the output register, and
    // drives the span channel directly.
    pird_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_item      (w_item),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .o_span      (o_span)
    );

endmodule
